>>> sv/rbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbg_pkg: shared definitions for the rpm bar gauge pixel renderer
// Speed thresholds, base colors, scale table, sequencer control word types
// and the dimming function.
// ----------------------------------------------------------------------------
package rbg_pkg;

   localparam int MAX_PIXELS_DEF = 32;
   localparam int RPM_W          = 16;
   localparam int COUNT_W        = 6;
   localparam int INDEX_W        = 5;
   localparam int COLOR_W        = 8;
   localparam int DELTA_W        = 13;
   localparam int QUOT_W         = 7;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd18;

   localparam int RPM_IDLE   = 800;
   localparam int RPM_TOP    = 6500;
   localparam int RPM_AMBER  = 4500;
   localparam int RPM_RED    = 5600;
   localparam int RPM_SPAN   = RPM_TOP - RPM_IDLE;
   localparam int SCALE_BASE = 80;

   localparam logic [COLOR_W-1:0] GREEN_R = 8'd0;
   localparam logic [COLOR_W-1:0] GREEN_G = 8'd90;
   localparam logic [COLOR_W-1:0] GREEN_B = 8'd24;
   localparam logic [COLOR_W-1:0] AMBER_R = 8'd110;
   localparam logic [COLOR_W-1:0] AMBER_G = 8'd72;
   localparam logic [COLOR_W-1:0] AMBER_B = 8'd0;
   localparam logic [COLOR_W-1:0] RED_R   = 8'd120;
   localparam logic [COLOR_W-1:0] RED_G   = 8'd0;
   localparam logic [COLOR_W-1:0] RED_B   = 8'd0;

   // whole part of SCALE_BASE / n, indexed by n (entry 0 unused)
   localparam logic [QUOT_W-1:0] SCALE_QUOT [65] = '{
      7'd0,  7'd80, 7'd40, 7'd26, 7'd20, 7'd16, 7'd13, 7'd11, 7'd10, 7'd8,
      7'd8,  7'd7,  7'd6,  7'd6,  7'd5,  7'd5,  7'd5,  7'd4,  7'd4,  7'd4,
      7'd4,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd2,  7'd2,  7'd2,
      7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,
      7'd2,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
      7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
      7'd1,  7'd1,  7'd1,  7'd1,  7'd1
   };

   typedef enum logic [1:0] {
      STEP_FETCH,
      STEP_PREP,
      STEP_EMIT,
      STEP_DONE
   } step_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_EMPTY,
      COND_MORE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     setup;
      logic     emit;
      logic     wait_slot;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic slot_free;
      logic empty;
      logic last;
   } status_type;

   function automatic logic [COLOR_W-1:0] video_scale(
      input logic [COLOR_W-1:0] c,
      input logic [COLOR_W-1:0] s
   );
      logic [2*COLOR_W-1:0] p;
      p = {{COLOR_W{1'b0}}, c} * {{COLOR_W{1'b0}}, s};
      if (c != '0 && s != '0) begin
         video_scale = p[2*COLOR_W-1:COLOR_W] + 8'd1;
      end else begin
         video_scale = p[2*COLOR_W-1:COLOR_W];
      end
   endfunction

endpackage
`default_nettype wire

>>> sv/rbg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbg_if: request and response channels of the gauge renderer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rbg_req_if;
   logic                          valid;
   logic                          ready;
   logic [rbg_pkg::RPM_W-1:0]     engine_rpm;

   modport source(output valid, output engine_rpm, input ready);
   modport sink(input valid, input engine_rpm, output ready);
endinterface

interface rbg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rbg_pkg::INDEX_W-1:0]   pixel_index;
   logic [rbg_pkg::COLOR_W-1:0]   red;
   logic [rbg_pkg::COLOR_W-1:0]   green;
   logic [rbg_pkg::COLOR_W-1:0]   blue;
   logic                          last_pixel;

   modport source(output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
   modport sink(input valid, input pixel_index, input red, input green,
                input blue, input last_pixel, output ready);
endinterface
`default_nettype wire

>>> sv/rbg_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbg_sequencer: microprogram store and step counter
// Reads one control word per step and picks the next step from a condition.
// ----------------------------------------------------------------------------
module rbg_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire rbg_pkg::status_type    status,
   output rbg_pkg::ctrl_word_type      ctrl,
   output rbg_pkg::step_type           step
);

   localparam rbg_pkg::ctrl_word_type PROGRAM [4] = '{
      '{req_ready: 1'b1, setup: 1'b0, emit: 1'b0, wait_slot: 1'b0,
        cond: rbg_pkg::COND_NO_REQ, target: rbg_pkg::STEP_FETCH},
      '{req_ready: 1'b0, setup: 1'b1, emit: 1'b0, wait_slot: 1'b0,
        cond: rbg_pkg::COND_EMPTY, target: rbg_pkg::STEP_FETCH},
      '{req_ready: 1'b0, setup: 1'b0, emit: 1'b1, wait_slot: 1'b1,
        cond: rbg_pkg::COND_MORE, target: rbg_pkg::STEP_EMIT},
      '{req_ready: 1'b0, setup: 1'b0, emit: 1'b0, wait_slot: 1'b0,
        cond: rbg_pkg::COND_ALWAYS, target: rbg_pkg::STEP_FETCH}
   };

   rbg_pkg::step_type pc_ff;
   rbg_pkg::step_type pc_in;
   logic              taken;

   assign ctrl = PROGRAM[pc_ff];
   assign step = pc_ff;

   always_comb begin
      case (ctrl.cond)
         rbg_pkg::COND_ALWAYS: taken = 1'b1;
         rbg_pkg::COND_NO_REQ: taken = !req_valid;
         rbg_pkg::COND_EMPTY:  taken = status.empty;
         rbg_pkg::COND_MORE:   taken = !status.last;
         default:              taken = 1'b0;
      endcase
      if (ctrl.wait_slot && !status.slot_free) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = rbg_pkg::step_type'(pc_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rbg_pkg::STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/rbg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbg_datapath: frame registers, ramp accumulators and output register
// Sets up a frame from one speed sample and renders one pixel per emit step.
// ----------------------------------------------------------------------------
module rbg_datapath #(
   parameter int MAX_PIXELS = rbg_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbg_pkg::ctrl_word_type        ctrl,
   input  wire logic                          req_accept,
   input  wire logic [rbg_pkg::RPM_W-1:0]     req_engine_rpm,
   input  wire logic                          csr_wr_en,
   input  wire logic [rbg_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [rbg_pkg::INDEX_W-1:0]        rsp_pixel_index,
   output logic [rbg_pkg::COLOR_W-1:0]        rsp_red,
   output logic [rbg_pkg::COLOR_W-1:0]        rsp_green,
   output logic [rbg_pkg::COLOR_W-1:0]        rsp_blue,
   output logic                               rsp_last_pixel,
   output rbg_pkg::status_type                status
);

   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int THR_W = $clog2(rbg_pkg::RPM_SPAN * MAX_PIXELS + 1);
   localparam int QW    = rbg_pkg::QUOT_W;
   localparam int CW    = rbg_pkg::COLOR_W;
   localparam int QIW   = $clog2($size(rbg_pkg::SCALE_QUOT));

   logic [rbg_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rbg_pkg::RPM_W-1:0]   rpm_ff, rpm_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [THR_W-1:0]            dn_ff, dn_in;
   logic [THR_W-1:0]            thr_ff, thr_in;
   logic [CNT_W-1:0]            i_ff, i_in;
   logic [QW-1:0]               q_ff, q_in;
   logic [QW-1:0]               qb_ff, qb_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]            rb_ff, rb_in;
   logic                        lit_en_ff, lit_en_in;
   logic [CW-1:0]               base_r_ff, base_r_in;
   logic [CW-1:0]               base_g_ff, base_g_in;
   logic [CW-1:0]               base_b_ff, base_b_in;
   logic                        out_valid_ff, out_valid_in;
   logic [rbg_pkg::INDEX_W-1:0] out_index_ff, out_index_in;
   logic [CW-1:0]               out_r_ff, out_r_in;
   logic [CW-1:0]               out_g_ff, out_g_in;
   logic [CW-1:0]               out_b_ff, out_b_in;
   logic                        out_last_ff, out_last_in;

   logic [rbg_pkg::DELTA_W-1:0] delta;
   logic [QW:0]                 qn;
   logic [CNT_W:0]              rem_sum;
   logic [CW-1:0]               scale;
   logic [QIW-1:0]              n_idx;
   logic                        lit;
   logic                        last;
   logic                        slot_free;
   logic                        emit_go;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit_go   = ctrl.emit && slot_free;
   assign last      = ((CNT_W + 1)'(i_ff) + 1'b1) == (CNT_W + 1)'(n_ff);
   assign lit       = lit_en_ff && (thr_ff <= dn_ff);
   assign scale     = CW'(rbg_pkg::SCALE_BASE) + CW'(q_ff);
   assign rem_sum   = (CNT_W + 1)'(rem_ff) + (CNT_W + 1)'(rb_ff);
   assign n_idx     = QIW'(n_ff);

   assign status.slot_free = slot_free;
   assign status.empty     = (n_ff == '0);
   assign status.last      = last;

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_red         = out_r_ff;
   assign rsp_green       = out_g_ff;
   assign rsp_blue        = out_b_ff;
   assign rsp_last_pixel  = out_last_ff;

   always_comb begin
      count_in  = count_ff;
      rpm_in    = rpm_ff;
      n_in      = n_ff;
      dn_in     = dn_ff;
      thr_in    = thr_ff;
      i_in      = i_ff;
      q_in      = q_ff;
      qb_in     = qb_ff;
      rem_in    = rem_ff;
      rb_in     = rb_ff;
      lit_en_in = lit_en_ff;
      base_r_in = base_r_ff;
      base_g_in = base_g_ff;
      base_b_in = base_b_ff;
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_r_in     = out_r_ff;
      out_g_in     = out_g_ff;
      out_b_in     = out_b_ff;
      out_last_in  = out_last_ff;

      if (rpm_ff < rbg_pkg::RPM_W'(rbg_pkg::RPM_IDLE)) begin
         delta = '0;
      end else if (rpm_ff > rbg_pkg::RPM_W'(rbg_pkg::RPM_TOP)) begin
         delta = rbg_pkg::DELTA_W'(rbg_pkg::RPM_SPAN);
      end else begin
         delta = rbg_pkg::DELTA_W'(rpm_ff - rbg_pkg::RPM_W'(rbg_pkg::RPM_IDLE));
      end
      qn = (QW + 1)'(rbg_pkg::SCALE_QUOT[n_idx]) * (QW + 1)'(n_ff);

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      if (req_accept) begin
         rpm_in = req_engine_rpm;
         if (int'(count_ff) > MAX_PIXELS) begin
            n_in = CNT_W'(MAX_PIXELS);
         end else begin
            n_in = CNT_W'(count_ff);
         end
      end

      if (ctrl.setup) begin
         dn_in     = THR_W'(delta) * THR_W'(n_ff);
         thr_in    = '0;
         i_in      = '0;
         q_in      = '0;
         rem_in    = '0;
         qb_in     = rbg_pkg::SCALE_QUOT[n_idx];
         rb_in     = CNT_W'((QW + 1)'(rbg_pkg::SCALE_BASE) - qn);
         lit_en_in = (rpm_ff >= rbg_pkg::RPM_W'(rbg_pkg::RPM_IDLE));
         if (rpm_ff >= rbg_pkg::RPM_W'(rbg_pkg::RPM_RED)) begin
            base_r_in = rbg_pkg::RED_R;
            base_g_in = rbg_pkg::RED_G;
            base_b_in = rbg_pkg::RED_B;
         end else if (rpm_ff >= rbg_pkg::RPM_W'(rbg_pkg::RPM_AMBER)) begin
            base_r_in = rbg_pkg::AMBER_R;
            base_g_in = rbg_pkg::AMBER_G;
            base_b_in = rbg_pkg::AMBER_B;
         end else begin
            base_r_in = rbg_pkg::GREEN_R;
            base_g_in = rbg_pkg::GREEN_G;
            base_b_in = rbg_pkg::GREEN_B;
         end
      end

      if (emit_go) begin
         out_valid_in = 1'b1;
         out_index_in = rbg_pkg::INDEX_W'(i_ff);
         out_last_in  = last;
         if (lit) begin
            out_r_in = rbg_pkg::video_scale(base_r_ff, scale);
            out_g_in = rbg_pkg::video_scale(base_g_ff, scale);
            out_b_in = rbg_pkg::video_scale(base_b_ff, scale);
         end else begin
            out_r_in = '0;
            out_g_in = '0;
            out_b_in = '0;
         end
         // advance to the next pixel
         i_in   = i_ff + 1'b1;
         thr_in = thr_ff + THR_W'(rbg_pkg::RPM_SPAN);
         if (rem_sum >= (CNT_W + 1)'(n_ff)) begin
            rem_in = CNT_W'(rem_sum - (CNT_W + 1)'(n_ff));
            q_in   = q_ff + qb_ff + 1'b1;
         end else begin
            rem_in = CNT_W'(rem_sum);
            q_in   = q_ff + qb_ff;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= rbg_pkg::COUNT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rpm_ff       <= rpm_in;
      n_ff         <= n_in;
      dn_ff        <= dn_in;
      thr_ff       <= thr_in;
      i_ff         <= i_in;
      q_ff         <= q_in;
      qb_ff        <= qb_in;
      rem_ff       <= rem_in;
      rb_ff        <= rb_in;
      lit_en_ff    <= lit_en_in;
      base_r_ff    <= base_r_in;
      base_g_ff    <= base_g_in;
      base_b_ff    <= base_b_in;
      out_index_ff <= out_index_in;
      out_r_ff     <= out_r_in;
      out_g_ff     <= out_g_in;
      out_b_ff     <= out_b_in;
      out_last_ff  <= out_last_in;
   end

endmodule
`default_nettype wire

>>> sv/rpm_bar_gauge_pixel_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_bar_gauge_pixel_renderer: bar gauge LED colors from engine speed
// One speed sample per frame in, one colored pixel per LED out, last marked.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    engine_rpm
//   rsp_chan  out  valid/ready    pixel_index, red, green, blue, last_pixel
//   csr_*     in   write enable   pixel_count (6 bits)
//
// A frame of n pixels steps through fetch, setup, n emit steps and done.
// The emit step of the microprogram renders one pixel per cycle into the
// output register and holds while that register is full and not taken.
// A zero pixel count ends the frame at setup with no item out.
// Reset is synchronous; it sets the pixel count to 18 and empties the output.
// ----------------------------------------------------------------------------
module rpm_bar_gauge_pixel_renderer #(
   parameter int MAX_PIXELS = rbg_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rbg_req_if.sink                            req_chan,
   rbg_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [rbg_pkg::COUNT_W-1:0]   csr_wr_data
);

   rbg_pkg::ctrl_word_type ctrl;
   rbg_pkg::status_type    status;
   rbg_pkg::step_type      step;
   logic                   req_accept;

   assign req_chan.ready = ctrl.req_ready;
   assign req_accept     = req_chan.valid && ctrl.req_ready;

   rbg_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl),
      .step      (step)
   );

   rbg_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_accept      (req_accept),
      .req_engine_rpm  (req_chan.engine_rpm),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_pixel_index (rsp_chan.pixel_index),
      .rsp_red         (rsp_chan.red),
      .rsp_green       (rsp_chan.green),
      .rsp_blue        (rsp_chan.blue),
      .rsp_last_pixel  (rsp_chan.last_pixel),
      .status          (status)
   );

`ifndef SYNTHESIS
   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> step == rbg_pkg::STEP_PREP)
      else $error("accepted item not followed by setup step");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && status.slot_free) |=> rsp_chan.valid)
      else $error("emit step did not load the output register");

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (step == rbg_pkg::STEP_EMIT) |-> !req_chan.ready)
      else $error("request taken during pixel emission");
`endif

endmodule
`default_nettype wire
